// ===== hdl/irn_pkg.sv =====
// Shared types and constants of the nearest-neighbor image rotator.
package irn_pkg;

   // Input item: pixel store or destination pixel fetch.
   typedef struct packed {
      logic        command;
      logic [8:0]  coord_x;
      logic [8:0]  coord_y;
      logic [31:0] pixel_in;
   } req_type;

   // Result item.
   typedef struct packed {
      logic [31:0] pixel_out;
      logic        inside_res;
      logic [9:0]  dest_width;
      logic [9:0]  dest_height;
   } rsp_type;

   // Saturated configuration and the derived destination geometry.
   typedef struct packed {
      logic signed [15:0] cos_q;
      logic signed [15:0] sin_q;
      logic [8:0]         src_w;
      logic [8:0]         src_h;
      logic [9:0]         dst_w;
      logic [9:0]         dst_h;
   } geo_type;

   // Classified item as it travels from the front end to the back end.
   // For a fetch, col and row hold the offsets from the destination center.
   typedef struct packed {
      logic [1:0]         op;
      logic signed [10:0] col;
      logic signed [10:0] row;
      logic [31:0]        pixel;
   } job_type;

   localparam logic [1:0] OP_EMPTY = 2'd0;
   localparam logic [1:0] OP_STORE = 2'd1;
   localparam logic [1:0] OP_FETCH = 2'd2;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   localparam logic [1:0] CSR_COS    = 2'd0;
   localparam logic [1:0] CSR_SIN    = 2'd1;
   localparam logic [1:0] CSR_WIDTH  = 2'd2;
   localparam logic [1:0] CSR_HEIGHT = 2'd3;

   localparam logic signed [15:0] TRIG_ONE     = 16'sd16384;
   localparam logic signed [15:0] TRIG_NEG_ONE = -16'sd16384;
   localparam int                 FRAC_BITS    = 14;
   localparam int                 CEIL_BIAS    = 16383;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_BITS = $clog2(QUEUE_DEPTH + 1);

endpackage

// ===== hdl/irn_cfg.sv =====
// Configuration registers and derived destination geometry of the rotator.
module irn_cfg #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_en,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wdata,
   output irn_pkg::geo_type  geo
);

   localparam int         W_CAP   = (MAX_WIDTH > 511) ? 511 : MAX_WIDTH;
   localparam int         H_CAP   = (MAX_HEIGHT > 511) ? 511 : MAX_HEIGHT;
   localparam logic [8:0] W_LIMIT = 9'(W_CAP);
   localparam logic [8:0] H_LIMIT = 9'(H_CAP);
   localparam logic [8:0] W_RESET = 9'((W_CAP < 256) ? W_CAP : 256);
   localparam logic [8:0] H_RESET = 9'((H_CAP < 256) ? H_CAP : 256);

   logic signed [15:0] cos_ff, cos_in;
   logic signed [15:0] sin_ff, sin_in;
   logic [8:0]         width_ff, width_in;
   logic [8:0]         height_ff, height_in;
   logic [14:0]        cos_abs, sin_abs;
   logic [23:0]        wc_ff, hs_ff, ws_ff, hc_ff;
   logic [24:0]        span_w, span_h;
   logic [10:0]        size_w, size_h;
   logic [9:0]         dst_w_ff, dst_h_ff;

   function automatic logic signed [15:0] sat_trig(input logic signed [15:0] raw);
      logic signed [15:0] v;
      v = raw;
      if (raw > irn_pkg::TRIG_ONE) begin
         v = irn_pkg::TRIG_ONE;
      end else if (raw < irn_pkg::TRIG_NEG_ONE) begin
         v = irn_pkg::TRIG_NEG_ONE;
      end
      return v;
   endfunction

   function automatic logic [8:0] sat_size(input logic [8:0] raw, input logic [8:0] cap);
      logic [8:0] v;
      v = raw;
      if (raw == 9'd0) begin
         v = 9'd1;
      end else if (raw > cap) begin
         v = cap;
      end
      return v;
   endfunction

   // Next values include reset so that the products below are right at the reset edge.
   always_comb begin
      cos_in    = cos_ff;
      sin_in    = sin_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (reset) begin
         cos_in    = irn_pkg::TRIG_ONE;
         sin_in    = '0;
         width_in  = W_RESET;
         height_in = H_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            irn_pkg::CSR_COS:    cos_in    = sat_trig($signed(csr_wdata));
            irn_pkg::CSR_SIN:    sin_in    = sat_trig($signed(csr_wdata));
            irn_pkg::CSR_WIDTH:  width_in  = sat_size(csr_wdata[8:0], W_LIMIT);
            irn_pkg::CSR_HEIGHT: height_in = sat_size(csr_wdata[8:0], H_LIMIT);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      cos_ff    <= cos_in;
      sin_ff    <= sin_in;
      width_ff  <= width_in;
      height_ff <= height_in;
   end

   assign cos_abs = cos_in[15] ? 15'(-cos_in) : cos_in[14:0];
   assign sin_abs = sin_in[15] ? 15'(-sin_in) : sin_in[14:0];

   always_ff @(posedge clock) begin
      wc_ff <= 24'(width_in) * 24'(cos_abs);
      hs_ff <= 24'(height_in) * 24'(sin_abs);
      ws_ff <= 24'(width_in) * 24'(sin_abs);
      hc_ff <= 24'(height_in) * 24'(cos_abs);
   end

   // Round the Q14 extents up to whole pixels.
   assign span_w = 25'(wc_ff) + 25'(hs_ff) + 25'(irn_pkg::CEIL_BIAS);
   assign span_h = 25'(ws_ff) + 25'(hc_ff) + 25'(irn_pkg::CEIL_BIAS);
   assign size_w = span_w[24:irn_pkg::FRAC_BITS];
   assign size_h = span_h[24:irn_pkg::FRAC_BITS];

   always_ff @(posedge clock) begin
      dst_w_ff <= (size_w == 11'd0) ? 10'd1 : size_w[9:0];
      dst_h_ff <= (size_h == 11'd0) ? 10'd1 : size_h[9:0];
   end

   assign geo.cos_q = cos_ff;
   assign geo.sin_q = sin_ff;
   assign geo.src_w = width_ff;
   assign geo.src_h = height_ff;
   assign geo.dst_w = dst_w_ff;
   assign geo.dst_h = dst_h_ff;

endmodule

// ===== hdl/irn_front.sv =====
// Front end: accepts items, checks bounds and centers destination coordinates.
module irn_front #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  irn_pkg::req_type                     req_data,
   input  irn_pkg::geo_type                     geo,
   input  logic [irn_pkg::QCOUNT_BITS-1:0]      queue_count,
   output logic                                 push_valid,
   output irn_pkg::job_type                     push_data
);

   localparam logic [12:0] STORE_W = 13'(MAX_WIDTH);
   localparam logic [12:0] STORE_H = 13'(MAX_HEIGHT);

   logic             accept;
   logic [3:0]       pending;
   logic             a_valid_ff;
   irn_pkg::req_type a_item_ff;
   logic             b_valid_ff;
   irn_pkg::job_type b_job_ff, b_job_in;

   // Items already in the front stages hold a queue slot in advance.
   assign pending   = 4'(queue_count) + 4'(a_valid_ff) + 4'(b_valid_ff);
   assign req_stall = reset || (pending >= 4'(irn_pkg::QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;

   always_comb begin
      b_job_in.op    = irn_pkg::OP_EMPTY;
      b_job_in.col   = $signed({2'b00, a_item_ff.coord_x});
      b_job_in.row   = $signed({2'b00, a_item_ff.coord_y});
      b_job_in.pixel = a_item_ff.pixel_in;
      if (a_item_ff.command == irn_pkg::CMD_WRITE) begin
         if (({4'b0, a_item_ff.coord_x} < STORE_W) && ({4'b0, a_item_ff.coord_y} < STORE_H)) begin
            b_job_in.op = irn_pkg::OP_STORE;
         end
      end else if (({1'b0, a_item_ff.coord_x} < geo.dst_w) &&
                   ({1'b0, a_item_ff.coord_y} < geo.dst_h)) begin
         b_job_in.op  = irn_pkg::OP_FETCH;
         b_job_in.col = $signed({2'b00, a_item_ff.coord_x}) - $signed({2'b00, geo.dst_w[9:1]});
         b_job_in.row = $signed({2'b00, a_item_ff.coord_y}) - $signed({2'b00, geo.dst_h[9:1]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= accept;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_item_ff <= req_data;
      end
      if (a_valid_ff) begin
         b_job_ff <= b_job_in;
      end
   end

   assign push_valid = b_valid_ff;
   assign push_data  = b_job_ff;

endmodule

// ===== hdl/irn_queue.sv =====
// Short first-in first-out queue between the front and back ends.
module irn_queue (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   input  irn_pkg::job_type                     push_data,
   input  logic                                 pop,
   output logic                                 pop_valid,
   output irn_pkg::job_type                     pop_data,
   output logic [irn_pkg::QCOUNT_BITS-1:0]      count
);

   localparam logic [irn_pkg::QPTR_BITS-1:0]   LAST_SLOT =
      irn_pkg::QPTR_BITS'(irn_pkg::QUEUE_DEPTH - 1);
   localparam logic [irn_pkg::QCOUNT_BITS-1:0] FULL_COUNT =
      irn_pkg::QCOUNT_BITS'(irn_pkg::QUEUE_DEPTH);

   irn_pkg::job_type                   slots_ff [irn_pkg::QUEUE_DEPTH];
   logic [irn_pkg::QPTR_BITS-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [irn_pkg::QCOUNT_BITS-1:0]    count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + irn_pkg::QCOUNT_BITS'(push) - irn_pkg::QCOUNT_BITS'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_valid = (count_ff != '0);
   assign pop_data  = slots_ff[rd_ptr_ff];
   assign count     = count_ff;

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != FULL_COUNT))
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("queue pop while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("queue count beyond depth");
`endif

endmodule

// ===== hdl/irn_back.sv =====
// Back end: inverse rotation, source bounds check and frame store access.
module irn_back #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int PIXEL_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  irn_pkg::geo_type  geo,
   input  logic              job_valid,
   input  irn_pkg::job_type  job_data,
   output logic              job_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output irn_pkg::rsp_type  rsp_data
);

   localparam int MEM_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_BITS = $clog2(MEM_DEPTH);

   logic                     advance;

   // Stage 1: products of the rotation.
   logic                     p1_valid_ff;
   logic [1:0]               p1_op_ff;
   logic [31:0]              p1_pixel_ff;
   logic signed [10:0]       p1_col_ff, p1_row_ff;
   logic signed [26:0]       p1_cx_ff, p1_sy_ff, p1_sx_ff, p1_cy_ff;

   // Stage 2: mapped source coordinates.
   logic                     p2_valid_ff;
   logic [1:0]               p2_op_ff;
   logic [31:0]              p2_pixel_ff;
   logic signed [11:0]       p2_bx_ff, p2_by_ff, p2_bx_in, p2_by_in;
   logic signed [27:0]       sum_u, sum_v;

   // Stage 3: bounds result and frame address.
   logic                     p3_valid_ff;
   logic                     p3_store_ff, p3_fetch_ff;
   logic [ADDR_BITS-1:0]     p3_addr_ff;
   logic [PIXEL_BITS-1:0]    p3_pixel_ff;
   logic                     in_src;

   // Stage 4: output register.
   logic                     p4_valid_ff;
   logic                     p4_fetch_ff;
   logic [PIXEL_BITS-1:0]    p4_data_ff;

   logic [PIXEL_BITS-1:0]    frame_mem [MEM_DEPTH];

   // The whole back end moves unless a finished result is held at the output.
   assign advance = !(p4_valid_ff && rsp_stall);
   assign job_pop = advance && job_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
         p4_valid_ff <= 1'b0;
      end else if (advance) begin
         p1_valid_ff <= job_valid;
         p2_valid_ff <= p1_valid_ff;
         p3_valid_ff <= p2_valid_ff;
         p4_valid_ff <= p3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p1_op_ff    <= job_data.op;
         p1_pixel_ff <= job_data.pixel;
         p1_col_ff   <= job_data.col;
         p1_row_ff   <= job_data.row;
         p1_cx_ff    <= 27'(geo.cos_q) * 27'(job_data.col);
         p1_sy_ff    <= 27'(geo.sin_q) * 27'(job_data.row);
         p1_sx_ff    <= 27'(geo.sin_q) * 27'(job_data.col);
         p1_cy_ff    <= 27'(geo.cos_q) * 27'(job_data.row);
      end
   end

   // Ceiling at the Q14 boundary is a bias and an arithmetic shift.
   assign sum_u = 28'(p1_cx_ff) + 28'(p1_sy_ff) + 28'(irn_pkg::CEIL_BIAS);
   assign sum_v = 28'(p1_cy_ff) - 28'(p1_sx_ff) + 28'(irn_pkg::CEIL_BIAS);

   always_comb begin
      p2_bx_in = 12'(p1_col_ff);
      p2_by_in = 12'(p1_row_ff);
      if (p1_op_ff == irn_pkg::OP_FETCH) begin
         p2_bx_in = $signed(sum_u[25:14]) + $signed({4'b0, geo.src_w[8:1]});
         p2_by_in = $signed(sum_v[25:14]) + $signed({4'b0, geo.src_h[8:1]});
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p2_op_ff    <= p1_op_ff;
         p2_pixel_ff <= p1_pixel_ff;
         p2_bx_ff    <= p2_bx_in;
         p2_by_ff    <= p2_by_in;
      end
   end

   assign in_src = !p2_bx_ff[11] && !p2_by_ff[11] &&
                   (p2_bx_ff[10:0] < {2'b00, geo.src_w}) &&
                   (p2_by_ff[10:0] < {2'b00, geo.src_h});

   always_ff @(posedge clock) begin
      if (advance) begin
         p3_store_ff <= (p2_op_ff == irn_pkg::OP_STORE);
         p3_fetch_ff <= (p2_op_ff == irn_pkg::OP_FETCH) && in_src;
         p3_addr_ff  <= ADDR_BITS'(p2_by_ff[10:0]) * ADDR_BITS'(MAX_WIDTH) +
                        ADDR_BITS'(p2_bx_ff[10:0]);
         p3_pixel_ff <= p2_pixel_ff[PIXEL_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (p3_valid_ff && p3_store_ff) begin
            frame_mem[p3_addr_ff] <= p3_pixel_ff;
         end
         p4_data_ff  <= frame_mem[p3_addr_ff];
         p4_fetch_ff <= p3_fetch_ff;
      end
   end

   assign rsp_valid            = p4_valid_ff;
   assign rsp_data.pixel_out   = p4_fetch_ff ? 32'(p4_data_ff) : 32'd0;
   assign rsp_data.inside_res  = p4_fetch_ff;
   assign rsp_data.dest_width  = geo.dst_w;
   assign rsp_data.dest_height = geo.dst_h;

endmodule

// ===== hdl/image_rotate_nearest.sv =====
// Top level of the nearest-neighbor image rotator about the image center.
// An accepted item passes the front stages, the queue and the back-end stages before its result is valid.
// Throughput: one item per cycle while not stalled; the frame store takes one store or fetch per cycle.
// The input side keeps accepting while a result is held, until queued and front-stage items fill the 4-entry queue.
// Reset is synchronous: control state clears and registers return to their defaults.
// The frame store is not cleared; a pixel must be written before it is fetched.
module image_rotate_nearest #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int PIXEL_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  irn_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output irn_pkg::rsp_type  rsp_data,
   input  logic              csr_write_en,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wdata
);

   irn_pkg::geo_type                     geo;
   logic                                 push_valid;
   irn_pkg::job_type                     push_data;
   logic                                 pop;
   logic                                 pop_valid;
   irn_pkg::job_type                     pop_data;
   logic [irn_pkg::QCOUNT_BITS-1:0]      queue_count;

   irn_cfg #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_cfg (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .geo          (geo)
   );

   irn_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .geo         (geo),
      .queue_count (queue_count),
      .push_valid  (push_valid),
      .push_data   (push_data)
   );

   irn_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_data),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .count     (queue_count)
   );

   irn_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .geo       (geo),
      .job_valid (pop_valid),
      .job_data  (pop_data),
      .job_pop   (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench of the nearest-neighbor image rotator with a mirrored frame store.
module tb_top;

   localparam int  STORE_WIDTH    = 256;
   localparam int  STORE_HEIGHT   = 256;
   localparam int  WATCHDOG_LIMIT = 3000;
   localparam int  PHASES         = 12;
   localparam int  PHASE_ITEMS    = 140;
   localparam real PI             = 3.14159265358979;

   // Mirrors the registers and the frame store, and holds the results still owed by the block.
   class rotation_board;
      logic [15:0]      cos_reg;
      logic [15:0]      sin_reg;
      logic [8:0]       width_reg;
      logic [8:0]       height_reg;
      bit [31:0]        frame [STORE_WIDTH * STORE_HEIGHT];
      bit               written [STORE_WIDTH * STORE_HEIGHT];
      irn_pkg::rsp_type expected_pixels [$];
      int               errors;

      function new();
         cos_reg    = irn_pkg::TRIG_ONE;
         sin_reg    = 16'd0;
         width_reg  = 9'd256;
         height_reg = 9'd256;
         errors     = 0;
      endfunction

      function void note_config(input logic [1:0] index, input logic [15:0] value);
         case (index)
            irn_pkg::CSR_COS:    cos_reg = value;
            irn_pkg::CSR_SIN:    sin_reg = value;
            irn_pkg::CSR_WIDTH:  width_reg = value[8:0];
            irn_pkg::CSR_HEIGHT: height_reg = value[8:0];
            default: ;
         endcase
      endfunction

      // Ceiling of a Q14 value, taken at the fraction boundary.
      function int ceil_frac(input int v);
         if (v >= 0) return (v + irn_pkg::CEIL_BIAS) / (1 << irn_pkg::FRAC_BITS);
         return -((-v) / (1 << irn_pkg::FRAC_BITS));
      endfunction

      function void geometry(output int c, output int s, output int w, output int h,
                             output int dw, output int dh);
         c = int'($signed(cos_reg));
         s = int'($signed(sin_reg));
         if (c > irn_pkg::TRIG_ONE) c = irn_pkg::TRIG_ONE;
         if (c < irn_pkg::TRIG_NEG_ONE) c = irn_pkg::TRIG_NEG_ONE;
         if (s > irn_pkg::TRIG_ONE) s = irn_pkg::TRIG_ONE;
         if (s < irn_pkg::TRIG_NEG_ONE) s = irn_pkg::TRIG_NEG_ONE;
         w = int'(width_reg);
         h = int'(height_reg);
         if (w < 1) w = 1;
         if (w > STORE_WIDTH) w = STORE_WIDTH;
         if (h < 1) h = 1;
         if (h > STORE_HEIGHT) h = STORE_HEIGHT;
         dw = ceil_frac(w * (c < 0 ? -c : c) + h * (s < 0 ? -s : s));
         dh = ceil_frac(w * (s < 0 ? -s : s) + h * (c < 0 ? -c : c));
         if (dw < 1) dw = 1;
         if (dh < 1) dh = 1;
      endfunction

      // Maps a destination pixel back into the source; false when it falls outside.
      function bit fetch_source(input int x, input int y, output int idx);
         int c, s, w, h, dw, dh, bx, by;
         idx = 0;
         geometry(c, s, w, h, dw, dh);
         if (x >= dw || y >= dh) return 1'b0;
         bx = ceil_frac(c * (x - dw / 2) + s * (y - dh / 2)) + w / 2;
         by = ceil_frac(-s * (x - dw / 2) + c * (y - dh / 2)) + h / 2;
         if (bx < 0 || bx >= w || by < 0 || by >= h) return 1'b0;
         idx = by * STORE_WIDTH + bx;
         return 1'b1;
      endfunction

      function void note_item(input irn_pkg::req_type item);
         irn_pkg::rsp_type want;
         int               c, s, w, h, dw, dh, idx;
         geometry(c, s, w, h, dw, dh);
         want.pixel_out   = '0;
         want.inside_res  = 1'b0;
         want.dest_width  = dw[9:0];
         want.dest_height = dh[9:0];
         if (item.command == irn_pkg::CMD_WRITE) begin
            if (item.coord_x < STORE_WIDTH && item.coord_y < STORE_HEIGHT) begin
               idx          = item.coord_y * STORE_WIDTH + item.coord_x;
               frame[idx]   = item.pixel_in;
               written[idx] = 1'b1;
            end
         end else if (fetch_source(int'(item.coord_x), int'(item.coord_y), idx)) begin
            want.pixel_out  = frame[idx];
            want.inside_res = 1'b1;
         end
         expected_pixels.push_back(want);
      endfunction

      function void mismatch(input string field, input logic [31:0] want,
                             input logic [31:0] got);
         errors++;
         $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
      endfunction

      function void check_result(input irn_pkg::rsp_type got);
         irn_pkg::rsp_type want;
         if (expected_pixels.size() == 0) begin
            errors++;
            $display("%0t: result with no item pending, expected none, got %h", $time, got);
            return;
         end
         want = expected_pixels.pop_front();
         if (got.pixel_out !== want.pixel_out)
            mismatch("pixel_out", want.pixel_out, got.pixel_out);
         if (got.inside_res !== want.inside_res)
            mismatch("inside_res", 32'(want.inside_res), 32'(got.inside_res));
         if (got.dest_width !== want.dest_width)
            mismatch("dest_width", 32'(want.dest_width), 32'(got.dest_width));
         if (got.dest_height !== want.dest_height)
            mismatch("dest_height", 32'(want.dest_height), 32'(got.dest_height));
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   irn_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   irn_pkg::rsp_type rsp_data;
   logic             csr_write_en = 1'b0;
   logic [1:0]       csr_index = irn_pkg::CSR_COS;
   logic [15:0]      csr_wdata = '0;

   bit            calm = 1'b0;
   int            stall_left = 0;
   rotation_board rotation = new();

   image_rotate_nearest dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Mostly no idling, often a short pause and now and then a long one.
   function automatic int idle_length();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int size_word();
      int r;
      r = $urandom_range(0, 7);
      if (r == 0) return STORE_WIDTH;
      if (r == 1) return $urandom_range(0, 65535);
      return $urandom_range(1, 20);
   endfunction

   task automatic send_item(input irn_pkg::req_type item);
      int gap;
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      rotation.note_item(item);
      gap = idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic issue(input logic command, input int x, input int y, input logic [31:0] pixel);
      irn_pkg::req_type item;
      int               idx;
      // A fetch must never land on a pixel that was never stored, so store that pixel first.
      if (command == irn_pkg::CMD_READ && rotation.fetch_source(x, y, idx) &&
          !rotation.written[idx]) begin
         item.command  = irn_pkg::CMD_WRITE;
         item.coord_x  = 9'(idx % STORE_WIDTH);
         item.coord_y  = 9'(idx / STORE_WIDTH);
         item.pixel_in = $urandom();
         send_item(item);
      end
      item.command  = command;
      item.coord_x  = 9'(x);
      item.coord_y  = 9'(y);
      item.pixel_in = pixel;
      send_item(item);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (rotation.expected_pixels.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [15:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= value;
      @(posedge clock);
      rotation.note_config(index, value);
   endtask

   task automatic set_config(input logic [15:0] cos_word, input logic [15:0] sin_word,
                             input logic [15:0] width_word, input logic [15:0] height_word);
      wait_idle();
      write_csr(irn_pkg::CSR_COS, cos_word);
      write_csr(irn_pkg::CSR_SIN, sin_word);
      write_csr(irn_pkg::CSR_WIDTH, width_word);
      write_csr(irn_pkg::CSR_HEIGHT, height_word);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         rotation.check_result(rsp_data);
      if (stall_left == 0) stall_left = idle_length();
      rsp_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left = stall_left - 1;
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid === 1'b1 && req_stall === 1'b0) ||
             (rsp_valid === 1'b1 && rsp_stall === 1'b0))
            quiet = 0;
         else
            quiet++;
      end
      $display("tb_top NOT OK");
      $finish;
   end

   initial begin
      real angle;
      int  cos_word, sin_word, width_word, height_word;
      int  c, s, w, h, dw, dh, pick;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings give an identity mapping over the full store.
      issue(irn_pkg::CMD_WRITE, 0, 0, 32'hFFFF_FFFF);
      issue(irn_pkg::CMD_WRITE, 255, 255, 32'h0000_0000);
      issue(irn_pkg::CMD_WRITE, 7, 0, 32'h0F0F_0F0F);
      issue(irn_pkg::CMD_WRITE, 255, 7, 32'hF0F0_F0F0);
      // Writes beyond the store are dropped and must not wrap onto stored pixels.
      issue(irn_pkg::CMD_WRITE, 7, 256, 32'hA5A5_A5A5);
      issue(irn_pkg::CMD_WRITE, 511, 7, 32'h5A5A_5A5A);
      issue(irn_pkg::CMD_READ, 0, 0, 32'h0000_0000);
      issue(irn_pkg::CMD_READ, 255, 255, 32'hFFFF_FFFF);
      issue(irn_pkg::CMD_READ, 7, 0, 32'h0000_0000);
      issue(irn_pkg::CMD_READ, 255, 7, 32'h0000_0000);
      issue(irn_pkg::CMD_READ, 256, 3, 32'h0000_0000);
      issue(irn_pkg::CMD_READ, 511, 511, 32'h0000_0000);

      // With both trig values zero the destination shrinks to a single pixel.
      set_config(16'h0000, 16'h0000, 16'd37, 16'd5);
      issue(irn_pkg::CMD_READ, 0, 0, 32'h0000_0000);
      issue(irn_pkg::CMD_READ, 1, 0, 32'h0000_0000);
      issue(irn_pkg::CMD_READ, 0, 1, 32'h0000_0000);

      // Trig values and sizes beyond their ranges saturate.
      set_config(16'h7FFF, 16'h8000, 16'h0000, 16'h01FF);
      issue(irn_pkg::CMD_READ, 0, 0, 32'h0000_0000);
      issue(irn_pkg::CMD_READ, 256, 256, 32'h0000_0000);
      issue(irn_pkg::CMD_READ, 128, 128, 32'h0000_0000);
      issue(irn_pkg::CMD_READ, 257, 0, 32'h0000_0000);

      // Half turn over the full store.
      set_config(-16'sd16384, 16'h0000, 16'd256, 16'd256);
      issue(irn_pkg::CMD_READ, 0, 0, 32'h0000_0000);
      issue(irn_pkg::CMD_READ, 255, 255, 32'h0000_0000);
      issue(irn_pkg::CMD_WRITE, 511, 511, 32'hFFFF_FFFF);
      issue(irn_pkg::CMD_READ, 300, 10, 32'h0000_0000);

      for (int phase = 0; phase < PHASES; phase++) begin
         calm = (phase % 4 == 3);
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            angle    = $urandom_range(0, 359) * PI / 180.0;
            cos_word = int'($cos(angle) * 16384.0);
            sin_word = int'($sin(angle) * 16384.0);
         end else if (pick < 8) begin
            cos_word = int'($urandom_range(0, 32768)) - 16384;
            sin_word = int'($urandom_range(0, 32768)) - 16384;
         end else begin
            cos_word = $urandom_range(0, 65535);
            sin_word = $urandom_range(0, 65535);
         end
         width_word  = size_word();
         height_word = size_word();
         if (phase == 0) begin
            width_word  = STORE_WIDTH;
            height_word = STORE_HEIGHT;
         end
         if (phase == 1) begin
            width_word  = 1;
            height_word = 1;
         end
         set_config(16'(cos_word), 16'(sin_word), 16'(width_word), 16'(height_word));
         rotation.geometry(c, s, w, h, dw, dh);

         // Mostly writes inside the source and reads inside the destination, some noise.
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
               issue(irn_pkg::CMD_WRITE, $urandom_range(0, w - 1), $urandom_range(0, h - 1),
                     $urandom());
            else if (pick < 85)
               issue(irn_pkg::CMD_READ, $urandom_range(0, dw - 1), $urandom_range(0, dh - 1),
                     $urandom());
            else
               issue(pick[0] ? irn_pkg::CMD_READ : irn_pkg::CMD_WRITE, $urandom_range(0, 511),
                     $urandom_range(0, 511), $urandom());
            if ((phase == 2 && n == PHASE_ITEMS / 2) || $urandom_range(0, 299) == 0)
               wait_idle();
         end
      end

      wait_idle();
      if (rotation.errors == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule
